// ----- hw/rtl/hsl_pkg.sv -----
// shared constants for the hsl to rgb converter pipeline
`timescale 1ns / 1ps

package hsl_pkg;

  // stream payload widths
  localparam int InDataW  = 32;
  localparam int OutDataW = 24;
  localparam int HueW     = 9;
  localparam int ByteW    = 8;

  // apb register map
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic [ByteW-1:0] GrayThresholdRst = 8'd26;

  // pipeline depth, input register to output register
  localparam int NumStages = 5;
  localparam int NumLanes  = 3;

  // arithmetic widths
  localparam int TermW = 16;  // t1, t2 and their difference, units of 1/65025
  localparam int WideW = 18;  // headroom while forming t1 and t2
  localparam int KW    = 6;   // hue weight 0..60
  localparam int NumW  = 22;  // 60*t2 + diff*k, at most 3901500
  localparam int QW    = 9;   // quotient estimate
  localparam int RemW  = 23;

  // hue constants
  localparam logic [HueW:0] HueFull  = 10'd360;
  localparam logic [HueW:0] Hue120   = 10'd120;
  localparam logic [HueW:0] Hue240   = 10'd240;
  localparam logic [HueW-1:0] Hue60  = 9'd60;
  localparam logic [HueW-1:0] Hue180 = 9'd180;
  localparam logic [HueW-1:0] Hue240n = 9'd240;
  localparam logic [KW-1:0] KFlat    = 6'd60;

  // division by 15300 as multiply by floor(2^30 / 15300) plus one correction
  localparam int RecipShift = 30;
  localparam int ProdW      = NumW + 17;
  localparam logic [16:0] Recip   = 17'd70179;
  localparam logic [13:0] Divisor = 14'd15300;
  localparam logic [QW:0] ByteMax = 10'd255;

endpackage

// ----- hw/rtl/hsl_to_rgb_converter.sv -----
// hsl to rgb converter: five stage pipeline with apb threshold register
// an accepted input request passes through stages 1 to 5 in order before m_axis_tvalid goes high
// throughput: one pixel per cycle while m_axis_tready does not stall the output
// each stage holds its request until the next frees, so a stall drops nothing
// reset clears all stage valid bits and loads gray_threshold with 26
`timescale 1ns / 1ps

module hsl_to_rgb_converter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // hue_degrees [8:0], saturation [16:9], luminance [24:17], zero pad
  input  logic [hsl_pkg::InDataW-1:0]        s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [hsl_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hsl_pkg::ApbAddrW-1:0]       paddr,
  input  logic [hsl_pkg::ApbDataW-1:0]       pwdata,
  output logic [hsl_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready
);

  localparam int NS = hsl_pkg::NumStages;
  localparam int NL = hsl_pkg::NumLanes;

  // config register
  logic [hsl_pkg::ByteW-1:0] gray_thr_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & ~paddr[2];
  assign prdata = paddr[2] ? '0 : {{(hsl_pkg::ApbDataW-hsl_pkg::ByteW){1'b0}}, gray_thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_thr_q <= hsl_pkg::GrayThresholdRst;
    end else if (cfg_wr) begin
      gray_thr_q <= pwdata[hsl_pkg::ByteW-1:0];
    end
  end

  // stage valid bits and backpressure chain
  logic [NS-1:0] vld_q;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = ~vld_q[NS-1] | m_axis_tready;
    for (int i = NS-2; i >= 0; i--) begin
      rdy[i] = ~vld_q[i] | rdy[i+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // stage 1: hue reduction, channel hue offsets, gray test, l*s
  logic [hsl_pkg::HueW-1:0]  hue_in;
  logic [hsl_pkg::ByteW-1:0] sat_in;
  logic [hsl_pkg::ByteW-1:0] lum_in;
  logic [hsl_pkg::HueW:0]    h_ext, h_mod, h_r, h_b, h_rw, h_bw;

  logic [NL-1:0][hsl_pkg::HueW-1:0] hue1_d, hue1_q;
  logic                             gray1_d, gray1_q;
  logic [hsl_pkg::ByteW-1:0]        lum1_q, sat1_q;
  logic [hsl_pkg::TermW-1:0]        prod1_d, prod1_q;

  assign hue_in = s_axis_tdata[8:0];
  assign sat_in = s_axis_tdata[16:9];
  assign lum_in = s_axis_tdata[24:17];

  always_comb begin
    h_ext     = {1'b0, hue_in};
    h_mod     = (h_ext >= hsl_pkg::HueFull) ? h_ext - hsl_pkg::HueFull : h_ext;
    h_r       = h_mod + hsl_pkg::Hue120;
    h_b       = h_mod + hsl_pkg::Hue240;
    h_rw      = (h_r >= hsl_pkg::HueFull) ? h_r - hsl_pkg::HueFull : h_r;
    h_bw      = (h_b >= hsl_pkg::HueFull) ? h_b - hsl_pkg::HueFull : h_b;
    hue1_d[0] = h_rw[hsl_pkg::HueW-1:0];
    hue1_d[1] = h_mod[hsl_pkg::HueW-1:0];
    hue1_d[2] = h_bw[hsl_pkg::HueW-1:0];
    gray1_d   = sat_in < gray_thr_q;
    prod1_d   = {8'b0, lum_in} * {8'b0, sat_in};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      hue1_q  <= hue1_d;
      gray1_q <= gray1_d;
      lum1_q  <= lum_in;
      sat1_q  <= sat_in;
      prod1_q <= prod1_d;
    end
  end

  // stage 2: intermediates t1, t2 and per-channel hue weight k
  logic [hsl_pkg::WideW-1:0] l18, s18, p18, lum255, sat255, t1, t2, diff;
  logic [NL-1:0][hsl_pkg::KW-1:0] k2_d, k2_q;
  logic [hsl_pkg::HueW-1:0]       fall [NL];
  logic [hsl_pkg::TermW-1:0]      t2_2_q, diff2_q;
  logic                           gray2_q;
  logic [hsl_pkg::ByteW-1:0]      lum2_q;

  always_comb begin
    l18    = {10'b0, lum1_q};
    s18    = {10'b0, sat1_q};
    p18    = {2'b0, prod1_q};
    lum255 = (l18 << 8) - l18;
    sat255 = (s18 << 8) - s18;
    // upper half of luminance uses l + s - l*s
    t1     = lum1_q[7] ? lum255 + sat255 - p18 : lum255 + p18;
    t2     = (lum255 << 1) - t1;
    diff   = t1 - t2;
    for (int c = 0; c < NL; c++) begin
      fall[c] = hsl_pkg::Hue240n - hue1_q[c];
      if (hue1_q[c] < hsl_pkg::Hue60) begin
        k2_d[c] = hue1_q[c][hsl_pkg::KW-1:0];
      end else if (hue1_q[c] < hsl_pkg::Hue180) begin
        k2_d[c] = hsl_pkg::KFlat;
      end else if (hue1_q[c] < hsl_pkg::Hue240n) begin
        k2_d[c] = fall[c][hsl_pkg::KW-1:0];
      end else begin
        k2_d[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      t2_2_q  <= t2[hsl_pkg::TermW-1:0];
      diff2_q <= diff[hsl_pkg::TermW-1:0];
      k2_q    <= k2_d;
      gray2_q <= gray1_q;
      lum2_q  <= lum1_q;
    end
  end

  // stage 3: scaled numerator 60*t2 + (t1-t2)*k per lane
  logic [hsl_pkg::NumW-1:0] t2w, base3;
  logic [NL-1:0][hsl_pkg::NumW-1:0] num3_d, num3_q;
  logic                      gray3_q;
  logic [hsl_pkg::ByteW-1:0] lum3_q;

  always_comb begin
    t2w   = {6'b0, t2_2_q};
    base3 = (t2w << 6) - (t2w << 2);
    for (int c = 0; c < NL; c++) begin
      num3_d[c] = base3 + ({6'b0, diff2_q} * {16'b0, k2_q[c]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      num3_q  <= num3_d;
      gray3_q <= gray2_q;
      lum3_q  <= lum2_q;
    end
  end

  // stage 4: quotient estimate by reciprocal multiply
  logic [NL-1:0][hsl_pkg::ProdW-1:0] prod4;
  logic [NL-1:0][hsl_pkg::QW-1:0]    qe4_q;
  logic [NL-1:0][hsl_pkg::NumW-1:0]  num4_q;
  logic                              gray4_q;
  logic [hsl_pkg::ByteW-1:0]         lum4_q;

  always_comb begin
    for (int c = 0; c < NL; c++) begin
      prod4[c] = hsl_pkg::ProdW'(num3_q[c]) * hsl_pkg::ProdW'(hsl_pkg::Recip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int c = 0; c < NL; c++) begin
        qe4_q[c] <= prod4[c][hsl_pkg::RecipShift +: hsl_pkg::QW];
      end
      num4_q  <= num3_q;
      gray4_q <= gray3_q;
      lum4_q  <= lum3_q;
    end
  end

  // stage 5: remainder correction, clamp, gray select into output register
  logic [NL-1:0][hsl_pkg::RemW-1:0]  back5, rem5;
  logic [NL-1:0][hsl_pkg::QW:0]      q5;
  logic [NL-1:0][hsl_pkg::ByteW-1:0] byte5_d, out_q;

  always_comb begin
    for (int c = 0; c < NL; c++) begin
      back5[c] = hsl_pkg::RemW'(qe4_q[c]) * hsl_pkg::RemW'(hsl_pkg::Divisor);
      rem5[c]  = hsl_pkg::RemW'(num4_q[c]) - back5[c];
      q5[c]    = (rem5[c] >= hsl_pkg::RemW'(hsl_pkg::Divisor))
                 ? {1'b0, qe4_q[c]} + 1'b1 : {1'b0, qe4_q[c]};
      if (gray4_q) begin
        byte5_d[c] = lum4_q;
      end else if (q5[c] > hsl_pkg::ByteMax) begin
        byte5_d[c] = '1;
      end else begin
        byte5_d[c] = q5[c][hsl_pkg::ByteW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      out_q <= byte5_d;
    end
  end

  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};

endmodule

// ----- hw/rtl/hsl_checker.sv -----
// port-level checker for the hsl to rgb converter, bound to the top level
`timescale 1ns / 1ps

module hsl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [hsl_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);

  localparam int CntW = $clog2(hsl_pkg::NumStages + 1);

  logic            in_acc, out_acc;
  logic [CntW-1:0] inflight_q;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  // requests inside the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CntW'(in_acc) - CntW'(out_acc);
    end
  end

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no result without an accepted request behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result without request");

  // pipeline never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(hsl_pkg::NumStages))
    else $error("pipeline over depth");

  // empty output register means the input side is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with free output");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (.*);
